// ----- hw/rtl/atcc_pkg.sv -----
// Package with the shared constants and register indexes of the averaged temperature control.
`default_nettype none

package atcc_pkg;

  // The sample window depth must be a power of two; the mean is a right shift.
  localparam int WINDOW_DEPTH = 8;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);

  // Field widths.
  localparam int RAW_W  = 12;
  localparam int TEMP_W = 13;
  localparam int HUM_W  = 10;
  localparam int BAND_W = 10;
  localparam int ACC_W  = TEMP_W + SLOT_W;
  localparam int CMP_W  = TEMP_W + 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = TEMP_W;

  localparam logic [RAW_W-1:0] ADC_OFFSET = RAW_W'(252);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_TARGET  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_BAND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_EN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AIR_EN      = 3'd5;

  // Register reset values.
  localparam logic [BAND_W-1:0] BAND_RESET      = BAND_W'(10);
  localparam logic [BAND_W-1:0] MODE_BAND_RESET = BAND_W'(20);

  typedef logic signed [CMP_W-1:0] cmp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/averaged_temperature_climate_control_unit.sv -----
// Top level of the averaged temperature climate control: window average and hysteresis control.
// An accepted beat is summed over the whole window by one shared adder, one entry at a time,
// then the decide state loads the average and control states into the output register.
// A new beat is taken only when idle; in_stall stays high through the sweep and the decision,
// and the decision waits while a stalled result still holds the output register.
// Reset (rst_n, synchronous, active low) clears the window, slot, control states and registers.
`default_nettype none

module averaged_temperature_climate_control_unit
  import atcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Input channel.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [RAW_W-1:0]      in_raw_temperature_sample,
  input  wire logic [HUM_W-1:0]      in_humidity_level,
  // Result channel.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [TEMP_W-1:0]          out_average_temperature,
  output logic                       out_pump_running,
  output logic                       out_heating_mode,
  output logic                       out_drying_air,
  output logic                       out_moistening_air
);

  // Sequencer state codes.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SUM    = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  // Configuration registers.
  logic [TEMP_W-1:0] temp_target_r;
  logic [HUM_W-1:0]  hum_target_r;
  logic [BAND_W-1:0] band_r;
  logic [BAND_W-1:0] mode_band_r;
  logic              heat_en_r;
  logic              air_en_r;

  // Datapath and control state.
  logic [1:0]        state_r, state_nxt;
  logic [TEMP_W-1:0] window_r [WINDOW_DEPTH];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] idx_r;
  logic [ACC_W-1:0]  acc_r;
  logic [HUM_W-1:0]  hum_r;
  logic              pump_r, pump_nxt;
  logic              heat_r, heat_nxt;
  logic              dry_r, dry_nxt;
  logic              wet_r, wet_nxt;

  // Output register.
  logic              out_valid_r;
  logic [TEMP_W-1:0] out_avg_r;
  logic              out_pump_r, out_heat_r, out_dry_r, out_wet_r;

  logic              in_accept;
  logic              out_take;
  logic              finish;
  logic [TEMP_W-1:0] scaled;
  logic [RAW_W-1:0]  raw_less;
  logic [TEMP_W-1:0] avg;
  cmp_t              t_s, sp_s, h_s, h2_s, hum_s, hsp_s;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign finish    = (state_r == ST_DECIDE) && (!out_valid_r || !out_stall);

  // Offset removal held at zero, then doubled.
  assign raw_less = in_raw_temperature_sample - ADC_OFFSET;
  assign scaled   = (in_raw_temperature_sample > ADC_OFFSET) ? {raw_less, 1'b0} : '0;

  // Advance the ring slot, wrapping at the window depth.
  assign slot_nxt = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;

  // Mean of a power-of-two window is the upper bits of the sum.
  assign avg = acc_r[SLOT_W +: TEMP_W];

  // Signed operands for the setpoint comparisons.
  assign t_s   = cmp_t'({1'b0, avg});
  assign sp_s  = cmp_t'({1'b0, temp_target_r});
  assign h_s   = cmp_t'({1'b0, band_r});
  assign h2_s  = cmp_t'({1'b0, mode_band_r});
  assign hum_s = cmp_t'({1'b0, hum_r});
  assign hsp_s = cmp_t'({1'b0, hum_target_r});

  // Heat/cool hysteresis machine.
  always_comb begin
    pump_nxt = pump_r;
    heat_nxt = heat_r;
    if (heat_en_r) begin
      if (heat_r) begin
        if (pump_r) begin
          if (t_s > sp_s + h_s) pump_nxt = 1'b0;
        end else if (t_s < sp_s - h_s) begin
          pump_nxt = 1'b1;
        end else if (t_s > sp_s + h2_s) begin
          heat_nxt = 1'b0;
          pump_nxt = 1'b1;
        end
      end else begin
        if (pump_r) begin
          if (t_s < sp_s - h_s) pump_nxt = 1'b0;
        end else if (t_s > sp_s + h_s) begin
          pump_nxt = 1'b1;
        end else if (t_s < sp_s - h2_s) begin
          heat_nxt = 1'b1;
          pump_nxt = 1'b1;
        end
      end
    end
  end

  // Dry/wet air toggle.
  always_comb begin
    dry_nxt = dry_r;
    wet_nxt = wet_r;
    if (air_en_r) begin
      if (dry_r) begin
        if (hum_s < hsp_s - h_s) begin
          dry_nxt = 1'b0;
          wet_nxt = 1'b1;
        end
      end else if (hum_s > hsp_s + h_s) begin
        dry_nxt = 1'b1;
        wet_nxt = 1'b0;
      end
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (idx_r == SLOT_W'(WINDOW_DEPTH - 1)) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (finish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_target_r <= '0;
      hum_target_r  <= '0;
      band_r        <= BAND_RESET;
      mode_band_r   <= MODE_BAND_RESET;
      heat_en_r     <= 1'b0;
      air_en_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_TARGET: temp_target_r <= cfg_data;
        REG_HUM_TARGET:  hum_target_r  <= cfg_data[HUM_W-1:0];
        REG_BAND:        band_r        <= cfg_data[BAND_W-1:0];
        REG_MODE_BAND:   mode_band_r   <= cfg_data[BAND_W-1:0];
        REG_HEAT_EN:     heat_en_r     <= cfg_data[0];
        REG_AIR_EN:      air_en_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer, ring write and control states.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
      idx_r   <= '0;
      pump_r  <= 1'b0;
      heat_r  <= 1'b0;
      dry_r   <= 1'b0;
      wet_r   <= 1'b0;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        window_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        slot_r           <= slot_nxt;
        window_r[slot_nxt] <= scaled;
        idx_r            <= '0;
      end else if (state_r == ST_SUM) begin
        idx_r <= idx_r + 1'b1;
      end
      if (finish) begin
        pump_r <= pump_nxt;
        heat_r <= heat_nxt;
        dry_r  <= dry_nxt;
        wet_r  <= wet_nxt;
      end
    end
  end

  // Shared adder sweeps the window one entry per cycle.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      acc_r <= '0;
      hum_r <= in_humidity_level;
    end else if (state_r == ST_SUM) begin
      acc_r <= acc_r + ACC_W'(window_r[idx_r]);
    end
  end

  // Output register holds a finished beat until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_avg_r  <= avg;
      out_pump_r <= pump_nxt;
      out_heat_r <= heat_nxt;
      out_dry_r  <= dry_nxt;
      out_wet_r  <= wet_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_average_temperature = out_avg_r;
  assign out_pump_running        = out_pump_r;
  assign out_heating_mode        = out_heat_r;
  assign out_drying_air          = out_dry_r;
  assign out_moistening_air      = out_wet_r;

endmodule

`default_nettype wire
